>>> rtl/balist_pkg.sv
// balist_pkg: shared constants, codes and structs of the bounded array list engine
// used by bal_store, bal_seq, bounded_array_list_engine and bal_checker
// no dependencies
package balist_pkg;

  localparam int CAPACITY = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 6;
  localparam int VAL_W    = 32;
  localparam int CMD_W    = 2;
  localparam int STAT_W   = 2;
  localparam int FOUND_W  = 5;
  localparam int FILL_W   = 6;
  localparam int CMP_W    = (POS_W > CNT_W) ? POS_W : CNT_W;

  // stream payload widths, padded to whole bytes
  localparam int S_DATA_BITS = POS_W + VAL_W;
  localparam int S_TDATA_W   = ((S_DATA_BITS + 7) / 8) * 8;
  localparam int M_DATA_BITS = VAL_W + FOUND_W + FILL_W;
  localparam int M_TDATA_W   = ((M_DATA_BITS + 7) / 8) * 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_SEARCH = 2'd3
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_REJECT = 2'd1,
    STAT_MISS   = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_INSERT,
    ST_DELETE,
    ST_SEARCH,
    ST_FINISH
  } seq_state_e;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [VAL_W-1:0] wdata;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    status_e          status;
    logic [VAL_W-1:0] removed;
    logic [IDX_W-1:0] found;
    logic [CNT_W-1:0] count;
  } result_t;

endpackage

>>> rtl/bal_store.sv
// bal_store: entry memory of the list, one write port and one registered read port
// depends on balist_pkg
module bal_store (
  input  logic                                  clk_i,
  input  balist_pkg::mem_req_t                  req_i,
  output logic [balist_pkg::VAL_W-1:0]          rdata_o
);

  logic [balist_pkg::VAL_W-1:0] mem [balist_pkg::CAPACITY];
  logic [balist_pkg::VAL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/bal_seq.sv
// bal_seq: command sequencer with the pointer unit and the key compare
// walks the entry memory one address per cycle; depends on balist_pkg
module bal_seq (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  balist_pkg::cmd_e                   cmd_i,
  input  logic [balist_pkg::POS_W-1:0]       pos_i,
  input  logic [balist_pkg::VAL_W-1:0]       val_i,
  output logic                               ready_o,
  output balist_pkg::mem_req_t               mem_o,
  input  logic [balist_pkg::VAL_W-1:0]       rdata_i,
  output balist_pkg::result_t                res_o,
  output logic                               done_o,
  input  logic                               out_free_i
);

  localparam int IDX_W = balist_pkg::IDX_W;
  localparam int CNT_W = balist_pkg::CNT_W;
  localparam int CMP_W = balist_pkg::CMP_W;

  balist_pkg::seq_state_e state_q, state_d;
  balist_pkg::cmd_e        cmd_q, cmd_d;
  balist_pkg::status_e     status_q, status_d;
  logic [balist_pkg::POS_W-1:0] pos_q, pos_d;
  logic [balist_pkg::VAL_W-1:0] val_q, val_d;
  logic [balist_pkg::VAL_W-1:0] removed_q, removed_d;
  logic [CNT_W-1:0]             count_q, count_d;
  logic [CNT_W-1:0]             ptr_q, ptr_d;
  logic [IDX_W-1:0]             rd_addr_q, rd_addr_d;
  logic [IDX_W-1:0]             wr_addr_q, wr_addr_d;
  logic [IDX_W-1:0]             found_q, found_d;
  logic                         rvalid_q, rvalid_d;

  logic [CNT_W-1:0] ptr_inc, ptr_dec;
  logic             not_full, pos_le_count, pos_lt_count, ptr_gt_pos, ptr_lt_count;
  logic             key_hit;

  // shared pointer unit and compares
  assign ptr_inc      = ptr_q + CNT_W'(1);
  assign ptr_dec      = ptr_q - CNT_W'(1);
  assign not_full     = count_q < CNT_W'(balist_pkg::CAPACITY);
  assign pos_le_count = CMP_W'(pos_q) <= CMP_W'(count_q);
  assign pos_lt_count = CMP_W'(pos_q) <  CMP_W'(count_q);
  assign ptr_gt_pos   = CMP_W'(ptr_q) >  CMP_W'(pos_q);
  assign ptr_lt_count = ptr_q < count_q;
  assign key_hit      = rvalid_q && (rdata_i == val_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= balist_pkg::ST_IDLE;
      count_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      rvalid_q <= rvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    pos_q     <= pos_d;
    val_q     <= val_d;
    status_q  <= status_d;
    removed_q <= removed_d;
    found_q   <= found_d;
    ptr_q     <= ptr_d;
    rd_addr_q <= rd_addr_d;
    wr_addr_q <= wr_addr_d;
  end

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    pos_d     = pos_q;
    val_d     = val_q;
    status_d  = status_q;
    removed_d = removed_q;
    found_d   = found_q;
    count_d   = count_q;
    ptr_d     = ptr_q;
    rd_addr_d = rd_addr_q;
    wr_addr_d = wr_addr_q;
    rvalid_d  = 1'b0;
    ready_o   = 1'b0;
    done_o    = 1'b0;
    mem_o.we    = 1'b0;
    mem_o.waddr = wr_addr_q;
    mem_o.wdata = rdata_i;
    mem_o.raddr = ptr_q[IDX_W-1:0];

    case (state_q)
      balist_pkg::ST_IDLE: begin
        ready_o = 1'b1;
        if (start_i) begin
          cmd_d   = cmd_i;
          pos_d   = pos_i;
          val_d   = val_i;
          state_d = balist_pkg::ST_DECIDE;
        end
      end

      balist_pkg::ST_DECIDE: begin
        status_d  = balist_pkg::STAT_OK;
        removed_d = '0;
        found_d   = '0;
        state_d   = balist_pkg::ST_FINISH;
        case (cmd_q)
          balist_pkg::CMD_APPEND: begin
            if (not_full) begin
              mem_o.we    = 1'b1;
              mem_o.waddr = count_q[IDX_W-1:0];
              mem_o.wdata = val_q;
              count_d     = count_q + CNT_W'(1);
            end else begin
              status_d = balist_pkg::STAT_REJECT;
            end
          end
          balist_pkg::CMD_INSERT: begin
            if (not_full && pos_le_count) begin
              ptr_d   = count_q;
              state_d = balist_pkg::ST_INSERT;
            end else begin
              status_d = balist_pkg::STAT_REJECT;
            end
          end
          balist_pkg::CMD_DELETE: begin
            if (pos_lt_count) begin
              ptr_d   = CNT_W'(pos_q);
              state_d = balist_pkg::ST_DELETE;
            end else begin
              status_d = balist_pkg::STAT_REJECT;
            end
          end
          balist_pkg::CMD_SEARCH: begin
            ptr_d   = '0;
            state_d = balist_pkg::ST_SEARCH;
          end
          default: begin
            status_d = balist_pkg::STAT_REJECT;
          end
        endcase
      end

      // read downward from the top, write each word one slot higher
      balist_pkg::ST_INSERT: begin
        mem_o.we = rvalid_q;
        if (ptr_gt_pos) begin
          mem_o.raddr = ptr_dec[IDX_W-1:0];
          rvalid_d    = 1'b1;
          wr_addr_d   = ptr_q[IDX_W-1:0];
          ptr_d       = ptr_dec;
        end else if (!rvalid_q) begin
          mem_o.we    = 1'b1;
          mem_o.waddr = pos_q[IDX_W-1:0];
          mem_o.wdata = val_q;
          count_d     = count_q + CNT_W'(1);
          state_d     = balist_pkg::ST_FINISH;
        end
      end

      // read upward from the hole, write each word one slot lower
      balist_pkg::ST_DELETE: begin
        if (rvalid_q) begin
          if (rd_addr_q == pos_q[IDX_W-1:0]) begin
            removed_d = rdata_i;
          end else begin
            mem_o.we = 1'b1;
          end
        end
        if (ptr_lt_count) begin
          rvalid_d  = 1'b1;
          rd_addr_d = ptr_q[IDX_W-1:0];
          wr_addr_d = ptr_dec[IDX_W-1:0];
          ptr_d     = ptr_inc;
        end else if (!rvalid_q) begin
          count_d = count_q - CNT_W'(1);
          state_d = balist_pkg::ST_FINISH;
        end
      end

      balist_pkg::ST_SEARCH: begin
        if (key_hit) begin
          found_d  = rd_addr_q;
          status_d = balist_pkg::STAT_OK;
          state_d  = balist_pkg::ST_FINISH;
        end else if (ptr_lt_count) begin
          rvalid_d  = 1'b1;
          rd_addr_d = ptr_q[IDX_W-1:0];
          ptr_d     = ptr_inc;
        end else if (!rvalid_q) begin
          status_d = balist_pkg::STAT_MISS;
          state_d  = balist_pkg::ST_FINISH;
        end
      end

      balist_pkg::ST_FINISH: begin
        done_o = 1'b1;
        if (out_free_i) begin
          state_d = balist_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = balist_pkg::ST_IDLE;
      end
    endcase
  end

  assign res_o.status  = status_q;
  assign res_o.removed = removed_q;
  assign res_o.found   = found_q;
  assign res_o.count   = count_q;

endmodule

>>> rtl/bounded_array_list_engine.sv
// bounded_array_list_engine: top level, stream ports and result register
// depends on balist_pkg, bal_store and bal_seq
//
//  channel  | dir | handshake                     | payload
//  s_axis   | in  | s_axis_tvalid / s_axis_tready | tuser command, tdata position, value
//  m_axis   | out | m_axis_tvalid / m_axis_tready | tuser status, tdata removed, found, fill
//
// the single read and single write port of the entry memory moves one word per cycle;
// one command is in work at a time; a new beat is taken while a finished result waits
// on m_axis. reset clears the fill count and control only, entry memory is left as is.
// a stalled m_axis holds the next result in its sequencer
module bounded_array_list_engine (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // bits: command[1:0]
  input  logic [balist_pkg::CMD_W-1:0]        s_axis_tuser,
  // bits: position[5:0], operand_value[37:6], zero pad
  input  logic [balist_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // bits: status[1:0]
  output logic [balist_pkg::STAT_W-1:0]       m_axis_tuser,
  // bits: removed_value[31:0], found_position[36:32], fill_count[42:37], zero pad
  output logic [balist_pkg::M_TDATA_W-1:0]    m_axis_tdata
);

  localparam int POS_W = balist_pkg::POS_W;
  localparam int VAL_W = balist_pkg::VAL_W;

  balist_pkg::mem_req_t       mem_req;
  balist_pkg::result_t        res, res_q;
  logic [VAL_W-1:0]           rdata;
  logic                       seq_ready, seq_done, out_free, in_beat;
  logic                       out_valid_q, out_valid_d;

  assign in_beat  = s_axis_tvalid && seq_ready;
  assign out_free = !out_valid_q || m_axis_tready;

  bal_store u_store (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  bal_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_beat),
    .cmd_i      (balist_pkg::cmd_e'(s_axis_tuser)),
    .pos_i      (s_axis_tdata[POS_W-1:0]),
    .val_i      (s_axis_tdata[POS_W+VAL_W-1:POS_W]),
    .ready_o    (seq_ready),
    .mem_o      (mem_req),
    .rdata_i    (rdata),
    .res_o      (res),
    .done_o     (seq_done),
    .out_free_i (out_free)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (seq_done && out_free) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_done && out_free) begin
      res_q <= res;
    end
  end

  assign s_axis_tready = seq_ready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = res_q.status;
  assign m_axis_tdata  = balist_pkg::M_TDATA_W'({
                           balist_pkg::FILL_W'(res_q.count),
                           balist_pkg::FOUND_W'(res_q.found),
                           res_q.removed});

endmodule

>>> rtl/bal_checker.sv
// bal_checker: port-level checks of the bounded array list engine, bound to the top
// depends on balist_pkg
module bal_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [balist_pkg::STAT_W-1:0]     m_axis_tuser,
  input logic [balist_pkg::M_TDATA_W-1:0]  m_axis_tdata
);

  logic [balist_pkg::FILL_W-1:0]  fill;
  logic [balist_pkg::FOUND_W-1:0] found;
  logic [balist_pkg::VAL_W-1:0]   removed;

  assign removed = m_axis_tdata[balist_pkg::VAL_W-1:0];
  assign found   = m_axis_tdata[balist_pkg::VAL_W+balist_pkg::FOUND_W-1:balist_pkg::VAL_W];
  assign fill    = m_axis_tdata[balist_pkg::M_DATA_BITS-1:balist_pkg::VAL_W+balist_pkg::FOUND_W];

  // result beat stays up until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat dropped before taken");

  // one command in work at a time
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while a command is in work");

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> fill <= balist_pkg::FILL_W'(balist_pkg::CAPACITY))
    else $error("fill count above capacity");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser != balist_pkg::STAT_W'(3))
    else $error("undefined status code");

  // a missed key reports no position and no removed word
  a_miss_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == balist_pkg::STAT_MISS |-> found == '0 && removed == '0)
    else $error("search miss with nonzero position or removed word");

endmodule

bind bounded_array_list_engine bal_checker u_bal_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tdata  (m_axis_tdata)
);
